[hdl/tlvd_pkg.sv]
// Shared types and codes for the TLV sub-element deframer.
package tlvd_pkg;

    // Parse position inside the buffer
    typedef enum logic [2:0] {
        PH_IE_HDR   = 3'd0,
        PH_SUB_HDR  = 3'd1,
        PH_SUB_PAY  = 3'd2,
        PH_SKIP_ID  = 3'd3,
        PH_SKIP_OUI = 3'd4
    } phase_t;

    // Record kinds
    localparam logic [1:0] REC_SUB = 2'd0;
    localparam logic [1:0] REC_ERR = 2'd1;
    localparam logic [1:0] REC_END = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_SHORT_IE_HDR  = 3'd0;
    localparam logic [2:0] ERR_OVER_MAX      = 3'd1;
    localparam logic [2:0] ERR_BEYOND_DATA   = 3'd2;
    localparam logic [2:0] ERR_BAD_ID        = 3'd3;
    localparam logic [2:0] ERR_BAD_OUI       = 3'd4;
    localparam logic [2:0] ERR_SHORT_SUB_HDR = 3'd5;
    localparam logic [2:0] ERR_OPEN_SUB      = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_ELEMENT_ID = 2'd0;
    localparam logic [1:0] CFG_OUI        = 2'd1;
    localparam logic [1:0] CFG_MAX_IE_LEN = 2'd2;
    localparam logic [1:0] CFG_DEV_SUB_ID = 2'd3;

    // Header sizes
    localparam logic [2:0] IE_HDR_LAST  = 3'd5;   // count value at sixth header byte
    localparam logic [2:0] SUB_HDR_LAST = 3'd2;   // count value at third sub header byte
    localparam logic [15:0] DEV_INFO_LEN = 16'd6;

    // One result beat
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [2:0]  error_code;
        logic [7:0]  sub_id;
        logic [15:0] sub_length;
        logic        is_device_info;
        logic        device_info_length_ok;
        logic [15:0] device_info_word;
        logic [15:0] control_port;
        logic [15:0] throughput_cap;
        logic        last_of_run;
    } rec_t;

endpackage

[hdl/ie_tlv_subelement_deframer_core.sv]
// Top level of the TLV information element / sub-element deframer.
//
// Channel  | Ports                         | Beat
// ---------+-------------------------------+------------------------------------
// input    | s_valid/s_ready, s_*          | one buffer byte (or empty marker)
// result   | m_valid/m_ready, m_*          | one record (sub done, error, end)
// config   | cfg_wr_en, cfg_index, cfg_wr_data | one register write, no wait
//
// Each accepted byte is parsed in the cycle it is taken: the parse state
// registers and up to two result records are written at that same edge.
// Records go into a 4-deep result queue; s_ready is high while the queue has
// room for two more, so bytes flow at one per cycle as long as the sink keeps
// pace (a stalled sink drops s_ready once three records are waiting).
// Reset (aresetn low, synchronous) empties the queue, returns parsing to the
// IE header phase and loads the configuration registers with their defaults.
module ie_tlv_subelement_deframer_core
    import tlvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,

    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        s_no_data,

    // record output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [2:0]  m_error_code,
    output logic [7:0]  m_sub_id,
    output logic [15:0] m_sub_length,
    output logic        m_is_device_info,
    output logic        m_device_info_length_ok,
    output logic [15:0] m_device_info_word,
    output logic [15:0] m_control_port,
    output logic [15:0] m_throughput_cap,
    output logic        m_last_of_run
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  elem_id_exp_reg;
    logic [31:0] oui_exp_reg;
    logic [7:0]  max_ie_len_reg;
    logic [7:0]  dev_sub_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_id_exp_reg <= 8'd221;
            oui_exp_reg     <= 32'h506F_9A0A;
            max_ie_len_reg  <= 8'd255;
            dev_sub_id_reg  <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ELEMENT_ID: elem_id_exp_reg <= cfg_wr_data[7:0];
                CFG_OUI:        oui_exp_reg     <= cfg_wr_data;
                CFG_MAX_IE_LEN: max_ie_len_reg  <= cfg_wr_data[7:0];
                CFG_DEV_SUB_ID: dev_sub_id_reg  <= cfg_wr_data[7:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    phase_t      phase_reg,      phase_next;
    logic [2:0]  hdr_cnt_reg,    hdr_cnt_next;    // shared IE / sub header count
    logic [7:0]  ie_len_reg,     ie_len_next;
    logic [7:0]  ie_id_reg,      ie_id_next;
    logic [31:0] oui_reg,        oui_next;
    logic [7:0]  ie_left_reg,    ie_left_next;
    logic [23:0] sub_hdr_reg,    sub_hdr_next;    // {id, len_hi, len_lo}
    logic [15:0] sub_left_reg,   sub_left_next;
    logic [47:0] sub_head_reg,   sub_head_next;   // first six payload bytes
    logic        collecting_reg, collecting_next; // sub-element payload open, may span into next IE
    logic        err_reg,        err_next;        // error flagged, skip to end

    // records produced by the current byte
    rec_t        rec0, rec1;
    logic [1:0]  rec_cnt;

    logic        in_fire;
    logic        out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    function automatic rec_t err_rec(input logic [2:0] code);
        rec_t r;
        r             = '0;
        r.record_kind = REC_ERR;
        r.error_code  = code;
        return r;
    endfunction

    function automatic rec_t sub_rec(input logic [23:0] hdr, input logic [47:0] head,
                                     input logic [7:0] dev_id);
        rec_t r;
        r                = '0;
        r.record_kind    = REC_SUB;
        r.sub_id         = hdr[23:16];
        r.sub_length     = hdr[15:0];
        r.is_device_info = (hdr[23:16] == dev_id);
        if (r.is_device_info && hdr[15:0] == DEV_INFO_LEN) begin
            r.device_info_length_ok = 1'b1;
            r.device_info_word      = head[47:32];
            r.control_port          = head[31:16];
            r.throughput_cap        = head[15:0];
        end
        return r;
    endfunction

    // One byte of parsing, straight from the input ports into next state
    always_comb begin
        logic [31:0] oui_shifted;
        logic        bad_id;
        logic        bad_oui;
        logic [15:0] pay_idx;
        logic        have_err;
        logic [2:0]  end_code;
        rec_t        rec_new;

        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        ie_len_next     = ie_len_reg;
        ie_id_next      = ie_id_reg;
        oui_next        = oui_reg;
        ie_left_next    = ie_left_reg;
        sub_hdr_next    = sub_hdr_reg;
        sub_left_next   = sub_left_reg;
        sub_head_next   = sub_head_reg;
        collecting_next = collecting_reg;
        err_next        = err_reg;
        rec0            = '0;
        rec1            = '0;
        rec_cnt         = 2'd0;
        oui_shifted     = {oui_reg[23:0], s_data_byte};
        bad_id          = (ie_id_reg != elem_id_exp_reg);
        bad_oui         = (oui_shifted != oui_exp_reg);
        pay_idx         = sub_hdr_reg[15:0] - sub_left_reg;
        have_err        = 1'b0;
        end_code        = ERR_SHORT_IE_HDR;
        rec_new         = '0;

        if (!s_no_data && !err_reg) begin
            if (phase_reg == PH_IE_HDR) begin
                // IE header: id, length, then four OUI bytes
                unique case (hdr_cnt_reg)
                    3'd0:    ie_id_next  = s_data_byte;
                    3'd1:    ie_len_next = s_data_byte;
                    default: oui_next    = oui_shifted;
                endcase
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                if (hdr_cnt_reg == IE_HDR_LAST) begin
                    hdr_cnt_next = 3'd0;
                    priority if (ie_len_reg > max_ie_len_reg) begin
                        rec_new = err_rec(ERR_OVER_MAX);
                        rec_cnt = 2'd1;
                    end else if (ie_len_reg == 8'd0) begin
                        // empty IE: id / OUI checked right away
                        if (bad_id) begin
                            rec_new = err_rec(ERR_BAD_ID);
                            rec_cnt = 2'd1;
                        end else if (bad_oui) begin
                            rec_new = err_rec(ERR_BAD_OUI);
                            rec_cnt = 2'd1;
                        end
                    end else begin
                        ie_left_next = ie_len_reg;
                        priority if (bad_id)      phase_next = PH_SKIP_ID;
                        else if (bad_oui)         phase_next = PH_SKIP_OUI;
                        else if (collecting_reg)  phase_next = PH_SUB_PAY;
                        else                      phase_next = PH_SUB_HDR;
                    end
                    err_next = (rec_cnt != 2'd0);
                end
            end else begin
                ie_left_next = ie_left_reg - 8'd1;
                if (phase_reg == PH_SUB_HDR) begin
                    sub_hdr_next = {sub_hdr_reg[15:0], s_data_byte};
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_reg == SUB_HDR_LAST) begin
                        hdr_cnt_next  = 3'd0;
                        sub_head_next = '0;
                        sub_left_next = sub_hdr_next[15:0];
                        if (sub_hdr_next[15:0] == 16'd0) begin
                            // zero-length sub-element completes at once
                            rec_new = sub_rec(sub_hdr_next, 48'd0, dev_sub_id_reg);
                            rec_cnt = 2'd1;
                        end else begin
                            collecting_next = 1'b1;
                            phase_next      = PH_SUB_PAY;
                        end
                    end
                end else if (phase_reg == PH_SUB_PAY) begin
                    unique case (pay_idx)
                        16'd0:   sub_head_next[47:40] = sub_head_reg[47:40] | s_data_byte;
                        16'd1:   sub_head_next[39:32] = sub_head_reg[39:32] | s_data_byte;
                        16'd2:   sub_head_next[31:24] = sub_head_reg[31:24] | s_data_byte;
                        16'd3:   sub_head_next[23:16] = sub_head_reg[23:16] | s_data_byte;
                        16'd4:   sub_head_next[15:8]  = sub_head_reg[15:8]  | s_data_byte;
                        16'd5:   sub_head_next[7:0]   = sub_head_reg[7:0]   | s_data_byte;
                        default: ;
                    endcase
                    sub_left_next = sub_left_reg - 16'd1;
                    if (sub_left_reg == 16'd1) begin
                        rec_new         = sub_rec(sub_hdr_reg, sub_head_next, dev_sub_id_reg);
                        rec_cnt         = 2'd1;
                        collecting_next = 1'b0;
                        phase_next      = PH_SUB_HDR;
                        hdr_cnt_next    = 3'd0;
                    end
                end
                // IE payload consumed
                if (ie_left_reg == 8'd1) begin
                    priority if (phase_next == PH_SUB_HDR && hdr_cnt_next != 3'd0) begin
                        rec_new  = err_rec(ERR_SHORT_SUB_HDR);
                        rec_cnt  = 2'd1;
                        err_next = 1'b1;
                    end else if (phase_next == PH_SKIP_ID) begin
                        rec_new  = err_rec(ERR_BAD_ID);
                        rec_cnt  = 2'd1;
                        err_next = 1'b1;
                    end else if (phase_next == PH_SKIP_OUI) begin
                        rec_new  = err_rec(ERR_BAD_OUI);
                        rec_cnt  = 2'd1;
                        err_next = 1'b1;
                    end else begin
                        phase_next   = PH_IE_HDR;
                        hdr_cnt_next = 3'd0;
                    end
                end
            end
            rec0 = rec_new;
        end

        // Buffer end: optional error replaces this byte's record, then end
        if (s_last_byte || s_no_data) begin
            if (!err_next) begin
                if (phase_next == PH_IE_HDR) begin
                    if (hdr_cnt_next != 3'd0) begin
                        have_err = 1'b1;
                        end_code = ERR_SHORT_IE_HDR;
                    end else if (collecting_next) begin
                        have_err = 1'b1;
                        end_code = ERR_OPEN_SUB;
                    end
                end else begin
                    have_err = 1'b1;
                    end_code = ERR_BEYOND_DATA;
                end
            end
            if (have_err) begin
                rec0 = err_rec(end_code);
                rec_cnt = 2'd1;
            end
            if (rec_cnt == 2'd0) begin
                rec0             = '0;
                rec0.record_kind = REC_END;
                rec_cnt          = 2'd1;
            end else begin
                rec1             = '0;
                rec1.record_kind = REC_END;
                rec_cnt          = 2'd2;
            end
            phase_next      = PH_IE_HDR;
            hdr_cnt_next    = 3'd0;
            ie_len_next     = 8'd0;
            ie_id_next      = 8'd0;
            oui_next        = 32'd0;
            ie_left_next    = 8'd0;
            sub_hdr_next    = 24'd0;
            sub_left_next   = 16'd0;
            sub_head_next   = 48'd0;
            collecting_next = 1'b0;
            err_next        = 1'b0;
        end

        // flag the final record of this byte
        if (rec_cnt == 2'd2) begin
            rec1.last_of_run = 1'b1;
        end else begin
            rec0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IE_HDR;
            hdr_cnt_reg    <= 3'd0;
            ie_len_reg     <= 8'd0;
            ie_id_reg      <= 8'd0;
            oui_reg        <= 32'd0;
            ie_left_reg    <= 8'd0;
            sub_hdr_reg    <= 24'd0;
            sub_left_reg   <= 16'd0;
            sub_head_reg   <= 48'd0;
            collecting_reg <= 1'b0;
            err_reg        <= 1'b0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            ie_len_reg     <= ie_len_next;
            ie_id_reg      <= ie_id_next;
            oui_reg        <= oui_next;
            ie_left_reg    <= ie_left_next;
            sub_hdr_reg    <= sub_hdr_next;
            sub_left_reg   <= sub_left_next;
            sub_head_reg   <= sub_head_next;
            collecting_reg <= collecting_next;
            err_reg        <= err_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: 4 entries, up to two written per accepted byte
    // ------------------------------------------------------------------
    rec_t       q_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] q_cnt_reg,  q_cnt_next;
    logic [1:0] push_cnt;
    rec_t       q_head;

    assign push_cnt = in_fire ? rec_cnt : 2'd0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, out_fire};
        q_cnt_next  = q_cnt_reg + {1'b0, push_cnt} - {2'b00, out_fire};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            q_cnt_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= rec0;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= rec1;
        end
    end

    assign s_ready = (q_cnt_reg <= 3'd2);
    assign m_valid = (q_cnt_reg != 3'd0);
    assign q_head  = q_reg[rd_ptr_reg];

    assign m_record_kind           = q_head.record_kind;
    assign m_error_code            = q_head.error_code;
    assign m_sub_id                = q_head.sub_id;
    assign m_sub_length            = q_head.sub_length;
    assign m_is_device_info        = q_head.is_device_info;
    assign m_device_info_length_ok = q_head.device_info_length_ok;
    assign m_device_info_word      = q_head.device_info_word;
    assign m_control_port          = q_head.control_port;
    assign m_throughput_cap        = q_head.throughput_cap;
    assign m_last_of_run           = q_head.last_of_run;

endmodule
